@@ rtl/tai_pkg.sv @@
// Package for the temperature alarm indicator: register map, reset values,
// remote command codes, LED color codes and siren sweep constants.
// No dependencies.
package tai_pkg;

    localparam int TEMP_W  = 12;
    localparam int TIME_W  = 16;
    localparam int TONE_W  = 11;
    localparam int RGB_W   = 3;
    localparam int ACT_W   = 2;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 5;

    localparam int SIREN_STEP_TICKS_DEF = 8;
    localparam int TIMER_BITS_DEF       = 32;

    // Siren sweep limits and step in Hz
    localparam logic [TONE_W-1:0] SWEEP_LOW  = 11'd500;
    localparam logic [TONE_W-1:0] SWEEP_HIGH = 11'd2000;
    localparam logic [TONE_W-1:0] SWEEP_STEP = 11'd5;

    // Register reset values
    localparam logic signed [TEMP_W-1:0] ALARM_LEVEL_RST  = 12'sd500;
    localparam logic signed [TEMP_W-1:0] HOT_LEVEL_RST    = 12'sd400;
    localparam logic signed [TEMP_W-1:0] WARM_LEVEL_RST   = 12'sd200;
    localparam logic signed [TEMP_W-1:0] COOL_LEVEL_RST   = 12'sd100;
    localparam logic signed [TEMP_W-1:0] FREEZE_LEVEL_RST = 12'sd0;
    localparam logic [TIME_W-1:0] RED_BLINK_PERIOD_RST    = 16'd200;
    localparam logic [TIME_W-1:0] BLUE_ON_TIME_RST        = 16'd1000;
    localparam logic [TIME_W-1:0] BLUE_OFF_TIME_RST       = 16'd500;

    // Register indexes (byte address is 4 * index)
    typedef enum logic [2:0] {
        REG_ALARM_LEVEL      = 3'd0,
        REG_HOT_LEVEL        = 3'd1,
        REG_WARM_LEVEL       = 3'd2,
        REG_COOL_LEVEL       = 3'd3,
        REG_FREEZE_LEVEL     = 3'd4,
        REG_RED_BLINK_PERIOD = 3'd5,
        REG_BLUE_ON_TIME     = 3'd6,
        REG_BLUE_OFF_TIME    = 3'd7
    } reg_index_t;

    // Remote commands
    typedef enum logic [ACT_W-1:0] {
        ACT_NONE      = 2'd0,
        ACT_LEDS_OFF  = 2'd1,
        ACT_LEDS_AUTO = 2'd2,
        ACT_MUTE      = 2'd3
    } action_t;

    // LED colors: bit2 red, bit1 green, bit0 blue
    localparam logic [RGB_W-1:0] RGB_OFF   = 3'b000;
    localparam logic [RGB_W-1:0] RGB_BLUE  = 3'b001;
    localparam logic [RGB_W-1:0] RGB_GREEN = 3'b010;
    localparam logic [RGB_W-1:0] RGB_CYAN  = 3'b011;
    localparam logic [RGB_W-1:0] RGB_RED   = 3'b100;

endpackage

@@ rtl/temperature_alarm_indicator.sv @@
// Temperature alarm indicator top level: tick input register, alarm, siren
// and LED logic, result register and APB register file.
// Depends on tai_pkg.

// One input beat is a 1 ms tick; each beat yields one result beat. The block
// takes a beat in every cycle unless the input and result registers are both
// full and out_ready is low: a beat is caught in an input register, then the
// mute latch, siren sweep and LED selection are worked out from it and the tick
// state and loaded into the result register. The result register holds a beat
// while out_ready is low and the input register keeps accepting until both are full.
// Configuration registers are written through the APB port at byte address
// 4*index; pready is always high and reads return the register value,
// sign-extended for the temperature levels.
module temperature_alarm_indicator #(
    parameter int SIREN_STEP_TICKS = tai_pkg::SIREN_STEP_TICKS_DEF,
    parameter int TIMER_BITS       = tai_pkg::TIMER_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // tick input
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [tai_pkg::TEMP_W-1:0]    temperature,
    input  logic                                 temp_valid,
    input  logic                                 button_pressed,
    input  logic [tai_pkg::ACT_W-1:0]            action,
    // result output
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [tai_pkg::RGB_W-1:0]            rgb,
    output logic [tai_pkg::TONE_W-1:0]           tone_freq,
    output logic                                 alarm_active,
    output logic                                 alarm_muted,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tai_pkg::ADDR_W-1:0]           paddr,
    input  logic [tai_pkg::DATA_W-1:0]           pwdata,
    output logic [tai_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready
);

    import tai_pkg::*;

    // configuration registers
    logic signed [TEMP_W-1:0] alarm_level_reg, hot_level_reg, warm_level_reg;
    logic signed [TEMP_W-1:0] cool_level_reg, freeze_level_reg;
    logic [TIME_W-1:0]        red_blink_period_reg, blue_on_time_reg, blue_off_time_reg;

    // input register
    logic                     s1_valid_reg;
    logic signed [TEMP_W-1:0] s1_temp_reg;
    logic                     s1_tvalid_reg;
    logic                     s1_button_reg;
    action_t                  s1_action_reg;

    // tick state
    logic [TIMER_BITS-1:0] tick_reg, last_red_reg, last_blue_reg, last_siren_reg;
    logic                  red_phase_reg, blue_phase_reg, muted_reg, cooled_reg;
    logic                  forced_off_reg, sweep_rising_reg;
    logic [TONE_W-1:0]     sweep_freq_reg, held_tone_reg;
    logic [RGB_W-1:0]      held_rgb_reg;

    logic [TIMER_BITS-1:0] last_red_next, last_blue_next, last_siren_next;
    logic                  red_phase_next, blue_phase_next, muted_next, cooled_next;
    logic                  forced_off_next, sweep_rising_next;
    logic [TONE_W-1:0]     sweep_freq_next, held_tone_next;
    logic [RGB_W-1:0]      held_rgb_next;
    logic                  active_next;

    // result register
    logic                  out_valid_reg;
    logic                  active_reg;

    logic s1_adv;
    logic cfg_wr;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_level_reg      <= ALARM_LEVEL_RST;
            hot_level_reg        <= HOT_LEVEL_RST;
            warm_level_reg       <= WARM_LEVEL_RST;
            cool_level_reg       <= COOL_LEVEL_RST;
            freeze_level_reg     <= FREEZE_LEVEL_RST;
            red_blink_period_reg <= RED_BLINK_PERIOD_RST;
            blue_on_time_reg     <= BLUE_ON_TIME_RST;
            blue_off_time_reg    <= BLUE_OFF_TIME_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_index_t'(paddr[4:2]))
                REG_ALARM_LEVEL:      alarm_level_reg      <= pwdata[TEMP_W-1:0];
                REG_HOT_LEVEL:        hot_level_reg        <= pwdata[TEMP_W-1:0];
                REG_WARM_LEVEL:       warm_level_reg       <= pwdata[TEMP_W-1:0];
                REG_COOL_LEVEL:       cool_level_reg       <= pwdata[TEMP_W-1:0];
                REG_FREEZE_LEVEL:     freeze_level_reg     <= pwdata[TEMP_W-1:0];
                REG_RED_BLINK_PERIOD: red_blink_period_reg <= pwdata[TIME_W-1:0];
                REG_BLUE_ON_TIME:     blue_on_time_reg     <= pwdata[TIME_W-1:0];
                REG_BLUE_OFF_TIME:    blue_off_time_reg    <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index_t'(paddr[4:2]))
            REG_ALARM_LEVEL:      prdata = DATA_W'(alarm_level_reg);
            REG_HOT_LEVEL:        prdata = DATA_W'(hot_level_reg);
            REG_WARM_LEVEL:       prdata = DATA_W'(warm_level_reg);
            REG_COOL_LEVEL:       prdata = DATA_W'(cool_level_reg);
            REG_FREEZE_LEVEL:     prdata = DATA_W'(freeze_level_reg);
            REG_RED_BLINK_PERIOD: prdata = {{(DATA_W-TIME_W){1'b0}}, red_blink_period_reg};
            REG_BLUE_ON_TIME:     prdata = {{(DATA_W-TIME_W){1'b0}}, blue_on_time_reg};
            REG_BLUE_OFF_TIME:    prdata = {{(DATA_W-TIME_W){1'b0}}, blue_off_time_reg};
            default:              prdata = '0;
        endcase
    end

    // ---------------------------------------------------------- input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_temp_reg   <= temperature;
            s1_tvalid_reg <= temp_valid;
            s1_button_reg <= button_pressed;
            s1_action_reg <= action_t'(action);
        end
    end

    // ------------------------------------------------------------ tick step
    always_comb
    begin
        logic                  hot;
        logic [TIMER_BITS-1:0] interval;
        logic [TONE_W-1:0]     nf;

        forced_off_next   = forced_off_reg;
        muted_next        = muted_reg;
        cooled_next       = cooled_reg;
        last_red_next     = last_red_reg;
        last_blue_next    = last_blue_reg;
        last_siren_next   = last_siren_reg;
        red_phase_next    = red_phase_reg;
        blue_phase_next   = blue_phase_reg;
        sweep_freq_next   = sweep_freq_reg;
        sweep_rising_next = sweep_rising_reg;
        held_tone_next    = held_tone_reg;
        held_rgb_next     = held_rgb_reg;
        interval          = '0;
        nf                = sweep_freq_reg;

        // apply the remote command first
        case (s1_action_reg)
            ACT_LEDS_OFF:  forced_off_next = 1'b1;
            ACT_LEDS_AUTO: forced_off_next = 1'b0;
            ACT_MUTE:
            begin
                muted_next  = 1'b1;
                cooled_next = 1'b0;
            end
            default: ;
        endcase

        // mute latch; a fall below the alarm level re-arms on the next rise
        hot = s1_tvalid_reg && (s1_temp_reg >= alarm_level_reg);
        if (s1_tvalid_reg)
        begin
            if (s1_button_reg && !muted_next && hot)
            begin
                muted_next  = 1'b1;
                cooled_next = 1'b0;
            end
            if (!hot)
                cooled_next = 1'b1;
            if (cooled_next && hot && muted_next)
            begin
                muted_next  = 1'b0;
                cooled_next = 1'b0;
            end
        end
        active_next = hot && !muted_next;

        // siren sweep
        if (active_next)
        begin
            if ((tick_reg - last_siren_reg) >= TIMER_BITS'(SIREN_STEP_TICKS))
            begin
                held_tone_next = sweep_freq_reg;
                nf = sweep_rising_reg ? sweep_freq_reg + SWEEP_STEP
                                      : sweep_freq_reg - SWEEP_STEP;
                if (nf >= SWEEP_HIGH)
                begin
                    nf                = SWEEP_HIGH;
                    sweep_rising_next = 1'b0;
                end
                if (nf <= SWEEP_LOW)
                begin
                    nf                = SWEEP_LOW;
                    sweep_rising_next = 1'b1;
                end
                sweep_freq_next = nf;
                last_siren_next = tick_reg;
            end
        end
        else
        begin
            held_tone_next = '0;
        end

        // LED selection
        if (forced_off_next || !s1_tvalid_reg)
        begin
            held_rgb_next = RGB_OFF;
        end
        else if (active_next)
        begin
            // touch the LEDs only when the blink toggles
            interval = TIMER_BITS'(red_blink_period_reg);
            if ((tick_reg - last_red_reg) >= interval)
            begin
                last_red_next  = tick_reg;
                red_phase_next = !red_phase_reg;
                held_rgb_next  = red_phase_next ? RGB_RED : RGB_OFF;
            end
        end
        else if (s1_temp_reg >= hot_level_reg)
            held_rgb_next = RGB_RED;
        else if (s1_temp_reg >= warm_level_reg)
            held_rgb_next = RGB_GREEN;
        else if (s1_temp_reg >= cool_level_reg)
            held_rgb_next = RGB_CYAN;
        else if (s1_temp_reg >= freeze_level_reg)
            held_rgb_next = RGB_BLUE;
        else
        begin
            interval = TIMER_BITS'(blue_phase_reg ? blue_on_time_reg : blue_off_time_reg);
            if ((tick_reg - last_blue_reg) >= interval)
            begin
                blue_phase_next = !blue_phase_reg;
                last_blue_next  = tick_reg;
            end
            held_rgb_next = blue_phase_next ? RGB_BLUE : RGB_OFF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg         <= '0;
            last_red_reg     <= '0;
            last_blue_reg    <= '0;
            last_siren_reg   <= '0;
            red_phase_reg    <= 1'b0;
            blue_phase_reg   <= 1'b1;
            muted_reg        <= 1'b0;
            cooled_reg       <= 1'b0;
            forced_off_reg   <= 1'b0;
            sweep_freq_reg   <= SWEEP_LOW;
            sweep_rising_reg <= 1'b1;
            held_tone_reg    <= '0;
            held_rgb_reg     <= RGB_OFF;
            active_reg       <= 1'b0;
        end
        else if (s1_adv)
        begin
            tick_reg         <= tick_reg + TIMER_BITS'(1);
            last_red_reg     <= last_red_next;
            last_blue_reg    <= last_blue_next;
            last_siren_reg   <= last_siren_next;
            red_phase_reg    <= red_phase_next;
            blue_phase_reg   <= blue_phase_next;
            muted_reg        <= muted_next;
            cooled_reg       <= cooled_next;
            forced_off_reg   <= forced_off_next;
            sweep_freq_reg   <= sweep_freq_next;
            sweep_rising_reg <= sweep_rising_next;
            held_tone_reg    <= held_tone_next;
            held_rgb_reg     <= held_rgb_next;
            active_reg       <= active_next;
        end
    end

    // ---------------------------------------------------------- result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // the held values double as the result payload
    assign out_valid    = out_valid_reg;
    assign rgb          = held_rgb_reg;
    assign tone_freq    = held_tone_reg;
    assign alarm_active = active_reg;
    assign alarm_muted  = muted_reg;

`ifndef SYNTHESIS
    a_silent_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !alarm_active |-> tone_freq == '0)
        else $error("tone present while siren is off");

    a_active_not_muted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && alarm_active |-> !alarm_muted)
        else $error("siren active while muted");

    a_tone_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> tone_freq == '0 || (tone_freq >= SWEEP_LOW && tone_freq <= SWEEP_HIGH))
        else $error("tone outside sweep range");

    a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_freq_reg >= SWEEP_LOW && sweep_freq_reg <= SWEEP_HIGH)
        else $error("sweep position out of range");

    a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid && tick_reg == $past(tick_reg) + TIMER_BITS'(1))
        else $error("tick counter or result register did not advance");
`endif

endmodule
